// File: hw/rtl/mlfq_pkg.sv
// Package for the three-level feedback queue scheduler.
// Holds the item types, codes, the job entry layout and the control states.
// No dependencies.
package mlfq_pkg;

	localparam int TIME_W = 23;
	localparam int VAL_W  = 16;
	localparam int CFG_W  = 16;

	localparam logic [VAL_W-1:0] L1Q_RESET = 16'd4;
	localparam logic [VAL_W-1:0] L2Q_RESET = 16'd8;

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_DISPATCH = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_NOP      = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_LOAD_OK  = 3'd0,
		ST_LOAD_REJ = 3'd1,
		ST_SLOT     = 3'd2,
		ST_ALL_DONE = 3'd3,
		ST_CLEARED  = 3'd4
	} status_t;

	typedef enum logic {
		CFG_L1Q = 1'b0,
		CFG_L2Q = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [VAL_W-1:0] arrival;
		logic [VAL_W-1:0] burst;
	} req_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [5:0]        job_index;
		logic [1:0]        level;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] end_time;
		logic              finished;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
	} rsp_item_t;

	// one job memory word
	typedef struct packed {
		logic             admitted;
		logic [VAL_W-1:0] arrival;
		logic [VAL_W-1:0] burst;
		logic [VAL_W-1:0] remain;
	} job_entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_FETCH,
		S_EXEC
	} state_t;

endpackage

// File: hw/rtl/mlfq_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module mlfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/mlfq_job_scheduler.sv
// Top level of the three-level feedback queue scheduler.
// Depends on mlfq_pkg and mlfq_ram.
//
// One item in, at most one result out (a no-op item gets none), one item at
// a time. A dispatch item admits arrived jobs by sweeping the job memory one
// entry per cycle (one read port, write-back in the cycle after the read),
// then pops the head of the highest-priority non-empty level (level 0 first)
// from the queue memory, reads the job back, runs it and writes back the
// remaining time. When all levels are empty, time must jump to the earliest
// pending arrival, which forces a second sweep. A dispatch after all jobs are
// done answers ST_ALL_DONE without a sweep. The admitted flag lives inside
// each job word and is cleared by the load that writes it, so there is no
// clearing pass after reset or clear. Quantum registers are written through
// cfg_we/cfg_index/cfg_data, only while idle; the block does not enforce
// that. A zero quantum runs the job to completion. Times wrap modulo 2^23.
module mlfq_job_scheduler
	import mlfq_pkg::*;
#(
	parameter int MAX_JOB_COUNT = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_item_t        req_item,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_item_t        rsp_item,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int IW  = $clog2(MAX_JOB_COUNT);
	localparam int CW  = IW + 1;
	// each level owns a ring of 2**IW slots, addressed as {level, slot}
	localparam int QAW = IW + 2;
	localparam int JW  = $bits(job_entry_t);

	state_t state_q, state_d;

	logic [CW-1:0]     job_cnt_q, done_cnt_q;
	logic [TIME_W-1:0] time_q;
	logic              running_q;
	logic [CW-1:0]     head_q [3];
	logic [CW-1:0]     tail_q [3];
	logic [VAL_W-1:0]  l1q_q, l2q_q;

	// sweep
	logic [CW-1:0]    scan_idx_q;
	logic             v_s1;
	logic [IW-1:0]    idx_s1;
	logic             pass_q;
	logic             best_vld_q;
	logic [VAL_W-1:0] best_q;

	logic [1:0]    lv_q;
	logic [IW-1:0] job_q;

	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	// memory ports
	logic             jw_en;
	logic [IW-1:0]    jw_addr, jr_addr;
	job_entry_t       jw_data, jrd;
	logic [JW-1:0]    jrd_raw;
	logic             qw_en;
	logic [QAW-1:0]   qw_addr, qr_addr;
	logic [IW-1:0]    qw_data, qrd;

	function automatic logic [QAW-1:0] qaddr(input logic [1:0] lv, input logic [CW-1:0] p);
		qaddr = {lv, p[IW-1:0]};
	endfunction

	mlfq_ram #(.WIDTH(JW), .DEPTH(MAX_JOB_COUNT)) u_job_ram (
		.clk   (clk),
		.we    (jw_en),
		.waddr (jw_addr),
		.wdata (jw_data),
		.raddr (jr_addr),
		.rdata (jrd_raw)
	);
	assign jrd = job_entry_t'(jrd_raw);

	mlfq_ram #(.WIDTH(IW), .DEPTH(3 * (1 << IW))) u_queue_ram (
		.clk   (clk),
		.we    (qw_en),
		.waddr (qw_addr),
		.wdata (qw_data),
		.raddr (qr_addr),
		.rdata (qrd)
	);

	// handshake
	logic accept, load_ok, work_left;
	assign req_stall = (state_q != S_IDLE) || rsp_valid_q;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;
	assign work_left = done_cnt_q < job_cnt_q;
	assign load_ok   = !running_q && (job_cnt_q < CW'(MAX_JOB_COUNT))
		&& (req_item.burst != '0);

	// level occupancy, pointers run free over twice the depth
	logic [2:0] nonempty;
	logic [1:0] pick_lv;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nonempty[k] = tail_q[k] != head_q[k];
		end
		if (nonempty[0]) begin
			pick_lv = 2'd0;
		end else if (nonempty[1]) begin
			pick_lv = 2'd1;
		end else begin
			pick_lv = 2'd2;
		end
	end

	// sweep stage 1 decision
	logic admit_s1, scan_done, rescan;
	assign admit_s1  = v_s1 && !jrd.admitted && ({7'd0, jrd.arrival} <= time_q);
	assign scan_done = (scan_idx_q == job_cnt_q) && !v_s1;
	assign rescan    = !pass_q && (nonempty == 3'b000);

	// slot execution
	logic [VAL_W-1:0]  quant, run, rem_n;
	logic [TIME_W-1:0] time_n, ta, wt;
	logic              fin;
	logic [1:0]        push_lv;
	always_comb begin
		unique case (lv_q)
			2'd0:    quant = l1q_q;
			2'd1:    quant = l2q_q;
			default: quant = jrd.remain;
		endcase
		run     = (quant == '0 || jrd.remain <= quant) ? jrd.remain : quant;
		rem_n   = jrd.remain - run;
		fin     = rem_n == '0;
		time_n  = time_q + TIME_W'(run);
		ta      = time_n - TIME_W'(jrd.arrival);
		wt      = ta - TIME_W'(jrd.burst);
		push_lv = (lv_q == 2'd0) ? 2'd1 : 2'd2;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req_item.opcode == OP_DISPATCH && work_left) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_done && !rescan) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				state_d = (nonempty != 3'b000) ? S_FETCH : S_IDLE;
			end
			S_FETCH: state_d = S_EXEC;
			S_EXEC:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		jw_en   = 1'b0;
		jw_addr = '0;
		jw_data = '0;
		jr_addr = '0;
		qw_en   = 1'b0;
		qw_addr = '0;
		qw_data = '0;
		qr_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req_item.opcode == OP_LOAD && load_ok) begin
					jw_en   = 1'b1;
					jw_addr = job_cnt_q[IW-1:0];
					jw_data = '{admitted: 1'b0, arrival: req_item.arrival,
						burst: req_item.burst, remain: req_item.burst};
				end
			end
			S_SCAN: begin
				jr_addr = scan_idx_q[IW-1:0];
				if (admit_s1) begin
					jw_en            = 1'b1;
					jw_addr          = idx_s1;
					jw_data          = jrd;
					jw_data.admitted = 1'b1;
					qw_en            = 1'b1;
					qw_addr          = qaddr(2'd0, tail_q[0]);
					qw_data          = idx_s1;
				end
			end
			S_PICK:  qr_addr = qaddr(pick_lv, head_q[pick_lv]);
			S_FETCH: jr_addr = qrd;
			S_EXEC: begin
				jw_en          = 1'b1;
				jw_addr        = job_q;
				jw_data        = jrd;
				jw_data.remain = rem_n;
				if (!fin) begin
					qw_en   = 1'b1;
					qw_addr = qaddr(push_lv, tail_q[push_lv]);
					qw_data = job_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_cnt_q   <= '0;
			done_cnt_q  <= '0;
			time_q      <= '0;
			running_q   <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				head_q[k] <= '0;
				tail_q[k] <= '0;
			end
			l1q_q       <= L1Q_RESET;
			l2q_q       <= L2Q_RESET;
			scan_idx_q  <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			pass_q      <= 1'b0;
			best_vld_q  <= 1'b0;
			best_q      <= '0;
			lv_q        <= '0;
			job_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			state_q <= state_d;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == CFG_L1Q) begin
					l1q_q <= cfg_data;
				end else begin
					l2q_q <= cfg_data;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					scan_idx_q <= '0;
					v_s1       <= 1'b0;
					pass_q     <= 1'b0;
					best_vld_q <= 1'b0;
					if (accept && req_item.opcode != OP_NOP) begin
						rsp_q <= '0;
						unique case (req_item.opcode)
							OP_LOAD: begin
								rsp_valid_q <= 1'b1;
								if (load_ok) begin
									rsp_q.status    <= ST_LOAD_OK;
									rsp_q.job_index <= 6'(job_cnt_q);
									job_cnt_q       <= job_cnt_q + 1'b1;
								end else begin
									rsp_q.status <= ST_LOAD_REJ;
								end
							end
							OP_CLEAR: begin
								rsp_valid_q  <= 1'b1;
								rsp_q.status <= ST_CLEARED;
								job_cnt_q    <= '0;
								done_cnt_q   <= '0;
								time_q       <= '0;
								running_q    <= 1'b0;
								for (int k = 0; k < 3; k++) begin
									head_q[k] <= '0;
									tail_q[k] <= '0;
								end
							end
							default: begin
								running_q <= 1'b1;
								if (!work_left) begin
									rsp_valid_q  <= 1'b1;
									rsp_q.status <= ST_ALL_DONE;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_idx_q != job_cnt_q) begin
						scan_idx_q <= scan_idx_q + 1'b1;
						v_s1       <= 1'b1;
						idx_s1     <= scan_idx_q[IW-1:0];
					end else begin
						v_s1 <= 1'b0;
					end
					if (admit_s1) begin
						tail_q[0] <= tail_q[0] + 1'b1;
					end else if (v_s1 && !jrd.admitted
						&& (!best_vld_q || jrd.arrival < best_q)) begin
						best_vld_q <= 1'b1;
						best_q     <= jrd.arrival;
					end
					// all levels empty: jump to earliest arrival, sweep again
					if (scan_done && rescan) begin
						if (best_vld_q) begin
							time_q <= TIME_W'(best_q);
						end
						pass_q     <= 1'b1;
						scan_idx_q <= '0;
						best_vld_q <= 1'b0;
					end
				end
				S_PICK: begin
					lv_q <= pick_lv;
					if (nonempty != 3'b000) begin
						head_q[pick_lv] <= head_q[pick_lv] + 1'b1;
					end else begin
						rsp_valid_q  <= 1'b1;
						rsp_q        <= '0;
						rsp_q.status <= ST_ALL_DONE;
					end
				end
				S_FETCH: job_q <= qrd;
				S_EXEC: begin
					time_q <= time_n;
					if (fin) begin
						done_cnt_q <= done_cnt_q + 1'b1;
					end else begin
						tail_q[push_lv] <= tail_q[push_lv] + 1'b1;
					end
					rsp_valid_q      <= 1'b1;
					rsp_q.status     <= ST_SLOT;
					rsp_q.job_index  <= 6'(job_q);
					rsp_q.level      <= lv_q;
					rsp_q.start_time <= time_q;
					rsp_q.end_time   <= time_n;
					rsp_q.finished   <= fin;
					rsp_q.turnaround <= fin ? ta : '0;
					rsp_q.waiting    <= fin ? wt : '0;
				end
				default: ;
			endcase
		end
	end

endmodule

// File: test/mlfq_job_scheduler_tb.sv
// Testbench for the three-level feedback queue scheduler.
// Self-checking: predicts each result item with an in-bench scheduler model.
// Depends on mlfq_pkg and the mlfq_job_scheduler RTL.
module mlfq_job_scheduler_tb
	import mlfq_pkg::*;
();

	localparam int JOBS = 64;
	localparam logic [TIME_W-1:0] TMASK = {TIME_W{1'b1}};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_item_t        req_item = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_item_t        rsp_item;
	logic             cfg_we = 1'b0;
	logic             cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;

	mlfq_job_scheduler i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// scheduler state mirror
	logic [VAL_W-1:0]  quantum1, quantum2;
	logic [VAL_W-1:0]  job_arr [JOBS];
	logic [VAL_W-1:0]  job_burst [JOBS];
	logic [VAL_W-1:0]  job_rem [JOBS];
	bit                job_in [JOBS];
	int unsigned       njobs, ndone;
	logic [TIME_W-1:0] now;
	bit                dispatching;
	int                lvq [3][$];

	req_item_t pending_items [$];
	rsp_item_t slots_due [$];
	int        n_errors;
	bit        quiet;   // no idling in the final stretch
	int        send_gap, take_gap;

	// accepted-at-last-edge flag for the driver
	bit req_stall_seen;

	function automatic void clear_sched();
		for (int i = 0; i < JOBS; i++) job_in[i] = 0;
		for (int k = 0; k < 3; k++) lvq[k].delete();
		njobs = 0;
		ndone = 0;
		now = '0;
		dispatching = 0;
	endfunction

	function automatic void admit_arrived();
		for (int i = 0; i < njobs; i++)
			if (!job_in[i] && TIME_W'(job_arr[i]) <= now) begin
				job_in[i] = 1;
				lvq[0].push_back(i);
			end
	endfunction

	function automatic rsp_item_t schedule_item(req_item_t it);
		rsp_item_t r;
		int lv, j;
		logic [VAL_W-1:0] q, run;
		int unsigned best;
		r = '0;
		case (opcode_t'(it.opcode))
			OP_CLEAR: begin
				clear_sched();
				r.status = ST_CLEARED;
			end
			OP_LOAD: begin
				if (dispatching || njobs >= JOBS || it.burst == 0) begin
					r.status = ST_LOAD_REJ;
				end else begin
					job_arr[njobs] = it.arrival;
					job_burst[njobs] = it.burst;
					job_rem[njobs] = it.burst;
					job_in[njobs] = 0;
					r.status = ST_LOAD_OK;
					r.job_index = 6'(njobs);
					njobs++;
				end
			end
			default: begin
				dispatching = 1;
				if (ndone >= njobs) begin
					r.status = ST_ALL_DONE;
					return r;
				end
				admit_arrived();
				if (lvq[0].size() == 0 && lvq[1].size() == 0 && lvq[2].size() == 0) begin
					best = 32'hFFFF_FFFF;
					for (int i = 0; i < njobs; i++)
						if (!job_in[i] && job_arr[i] < best) best = job_arr[i];
					if (best != 32'hFFFF_FFFF) now = TIME_W'(best);
					admit_arrived();
				end
				lv = -1;
				for (int k = 2; k >= 0; k--) if (lvq[k].size() != 0) lv = k;
				if (lv < 0) begin
					r.status = ST_ALL_DONE;
					return r;
				end
				j = lvq[lv].pop_front();
				q = (lv == 0) ? quantum1 : (lv == 1) ? quantum2 : job_rem[j];
				run = (q == 0 || job_rem[j] <= q) ? job_rem[j] : q;
				r.status = ST_SLOT;
				r.job_index = 6'(j);
				r.level = 2'(lv);
				r.start_time = now;
				now = (now + TIME_W'(run)) & TMASK;
				job_rem[j] -= run;
				r.end_time = now;
				if (job_rem[j] == 0) begin
					ndone++;
					r.finished = 1'b1;
					r.turnaround = now - TIME_W'(job_arr[j]);
					r.waiting = r.turnaround - TIME_W'(job_burst[j]);
				end else begin
					lvq[lv == 0 ? 1 : 2].push_back(j);
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d", what, got, want);
		n_errors++;
	endtask

	// driver: present items from the queue and drive random result stalls at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall_seen) begin
				// previous item still stalled: hold it
			end else if (send_gap > 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				req_item <= pending_items.pop_front();
				req_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 9);
			end else begin
				req_valid <= 1'b0;
			end
			if (take_gap > 0) begin
				take_gap--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				if (!quiet && $urandom_range(0, 9) == 0) take_gap = $urandom_range(1, 9);
			end
		end
	end

	// predictor: a no-op item is accepted but answers nothing
	always @(posedge clk) begin
		req_stall_seen <= req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall && req_item.opcode != OP_NOP)
			slots_due.push_back(schedule_item(req_item));
	end

	// monitor
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (slots_due.size() == 0) begin
				report_mismatch("unexpected result item", 1, 0);
			end else begin
				want = slots_due.pop_front();
				if (rsp_item.status !== want.status)
					report_mismatch("status", rsp_item.status, want.status);
				if (rsp_item.job_index !== want.job_index)
					report_mismatch("job_index", rsp_item.job_index, want.job_index);
				if (rsp_item.level !== want.level)
					report_mismatch("level", rsp_item.level, want.level);
				if (rsp_item.start_time !== want.start_time)
					report_mismatch("start_time", rsp_item.start_time, want.start_time);
				if (rsp_item.end_time !== want.end_time)
					report_mismatch("end_time", rsp_item.end_time, want.end_time);
				if (rsp_item.finished !== want.finished)
					report_mismatch("finished", rsp_item.finished, want.finished);
				if (rsp_item.turnaround !== want.turnaround)
					report_mismatch("turnaround", rsp_item.turnaround, want.turnaround);
				if (rsp_item.waiting !== want.waiting)
					report_mismatch("waiting", rsp_item.waiting, want.waiting);
			end
		end
	end

	function automatic req_item_t mk(opcode_t op, int arr, int bst);
		req_item_t it;
		it.opcode = op;
		it.arrival = VAL_W'(arr);
		it.burst = VAL_W'(bst);
		return it;
	endfunction

	// wait until everything queued has been answered, then let the block settle
	task automatic drain();
		while (pending_items.size() != 0 || req_valid || slots_due.size() != 0)
			@(posedge clk);
		repeat (2 * JOBS + 20) @(posedge clk);
	endtask

	task automatic write_quantum(cfg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_L1Q) quantum1 = val;
		else quantum2 = val;
	endtask

	// one job set: n loads, then 3n+2 mostly dispatch items with stray loads and no-ops, then usually a clear
	task automatic queue_job_set(int n, int max_arr, int max_bst);
		for (int i = 0; i < n; i++)
			pending_items.push_back(mk(OP_LOAD, $urandom_range(0, max_arr),
				$urandom_range(1, max_bst)));
		for (int i = 0; i < 3 * n + 2; i++) begin
			case ($urandom_range(0, 19))
				0: pending_items.push_back(mk(OP_LOAD, $urandom, $urandom));
				1: pending_items.push_back(mk(OP_NOP, $urandom, $urandom));
				default: pending_items.push_back(mk(OP_DISPATCH, $urandom, $urandom));
			endcase
		end
		if ($urandom_range(0, 9) != 0) pending_items.push_back(mk(OP_CLEAR, 0, 0));
	endtask

	initial begin
		n_errors = 0;
		quiet = 0;
		send_gap = 0;
		take_gap = 0;
		quantum1 = L1Q_RESET;
		quantum2 = L2Q_RESET;
		clear_sched();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: dispatch with nothing loaded, zero burst, extremes, nop, late load
		pending_items.push_back(mk(OP_DISPATCH, 0, 0));
		pending_items.push_back(mk(OP_LOAD, 1, 1));
		pending_items.push_back(mk(OP_CLEAR, 0, 0));
		pending_items.push_back(mk(OP_LOAD, 0, 0));
		pending_items.push_back(mk(OP_LOAD, 65535, 65535));
		pending_items.push_back(mk(OP_LOAD, 0, 1));
		pending_items.push_back(mk(OP_LOAD, 3, 10));
		pending_items.push_back(mk(OP_NOP, 65535, 65535));
		for (int i = 0; i < 12; i++) pending_items.push_back(mk(OP_DISPATCH, 0, 0));
		pending_items.push_back(mk(OP_LOAD, 2, 2));
		pending_items.push_back(mk(OP_CLEAR, 0, 0));
		drain();

		// full table, then one load too many; large bursts
		for (int i = 0; i < JOBS; i++)
			pending_items.push_back(mk(OP_LOAD, $urandom, 65535 - i));
		pending_items.push_back(mk(OP_LOAD, 5, 5));
		for (int i = 0; i < 2 * JOBS + 3; i++) pending_items.push_back(mk(OP_DISPATCH, 0, 0));
		pending_items.push_back(mk(OP_CLEAR, 0, 0));
		drain();

		// random phases across quantum settings, extremes included
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin write_quantum(CFG_L1Q, 16'd1); write_quantum(CFG_L2Q, 16'hFFFF); end
				1: begin write_quantum(CFG_L1Q, 16'hFFFF); write_quantum(CFG_L2Q, 16'd1); end
				2: begin write_quantum(CFG_L1Q, 16'd0); write_quantum(CFG_L2Q, 16'd0); end
				3: begin write_quantum(CFG_L1Q, 16'd2); write_quantum(CFG_L2Q, 16'd0); end
				default: begin
					write_quantum(CFG_L1Q, VAL_W'($urandom_range(1, 12)));
					write_quantum(CFG_L2Q, VAL_W'($urandom_range(1, 24)));
				end
			endcase
			if (ph == 7) quiet = 1;
			for (int s = 0; s < 6; s++) begin
				if (ph == 5 && s == 0) queue_job_set(JOBS, 65535, 65535);
				else queue_job_set($urandom_range(1, 10), $urandom_range(0, 1) ? 40 : 65535,
					$urandom_range(0, 1) ? 20 : 65535);
			end
			pending_items.push_back(mk(OP_CLEAR, 0, 0));
			drain();
		end

		if (n_errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
